// ===== src/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants of the SHA-1 digest unit.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

endpackage

// ===== src/sha1_if.sv =====
// ----------------------------------------------------------------------------
// sha1_in_if / sha1_out_if
// Valid/ready channels of the SHA-1 digest unit.
// ----------------------------------------------------------------------------
interface sha1_in_if;
  logic                 valid;
  logic                 ready;
  sha1_pkg::in_beat_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sha1_out_if;
  logic                 valid;
  logic                 ready;
  sha1_pkg::out_beat_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/sha1_message_digest_unit.sv =====
// ----------------------------------------------------------------------------
// sha1_message_digest_unit
// SHA-1 over a byte stream, block buffer kept in one RAM, schedule in registers.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one beat per byte (data_byte valid when byte_present), with
//         end_of_message closing the message after that beat's byte.
//         A beat with neither is accepted and does nothing.
//   out : five digest words, word_index 0..4, last_word on word 4.
// Timing:
//   A byte beat that does not fill the block: RAM read on accept, merge
//   and write back on the next cycle.
//   A byte completing the block starts the compression: the 16 block
//   words are loaded into the schedule window, 80 rounds run at one per
//   cycle, then the chaining add and a decision step. The next beat is
//   taken only after that decision step.
//   An end mark pads one byte at a time through S_PAD and S_WRITE (0x80,
//   zero fill, 8 length bytes), runs one or two compressions, then shows
//   the five words on the output register, one per beat.
// Reset: chaining words to the IV, counts to zero; buffer content is left
//   undefined and every entry is written before it is used.
// Stall: while digest words wait for the receiver the block takes no input.
// ----------------------------------------------------------------------------
module sha1_message_digest_unit (
  input logic clk,
  input logic rst,
  sha1_in_if.sink    in_ch,
  sha1_out_if.source out_ch
);
  import sha1_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WRITE = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_ROUND = 7'b0001000,
    S_ADD   = 7'b0010000,
    S_PAD   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t      state;
  logic [31:0] buf_mem [16];
  logic [31:0] rd_word;
  logic [3:0]  rd_addr;
  logic        wr_en;
  logic [3:0]  wr_addr;
  logic [31:0] wr_word;

  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [31:0] w [16];
  logic [63:0] bit_count;
  logic [63:0] length;
  logic [5:0]  fill;
  logic [6:0]  round;
  logic [4:0]  load_cnt;
  logic [7:0]  cur_byte;
  logic        closing;       // padding in progress
  logic        pad_started;   // 0x80 already queued
  logic        length_phase;  // length bytes being written
  logic        pad_done;      // last length byte written
  logic [2:0]  out_idx;

  // RAM: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_mem[wr_addr] <= wr_word;
    end
    rd_word <= buf_mem[rd_addr];
  end

  // next pad byte: zero fill, or the length big-endian from byte 56 on
  logic [7:0] pad_byte;
  logic [2:0] lsel;
  always_comb begin
    lsel = 3'd7 - fill[2:0];
    pad_byte = 8'h00;
    if (length_phase || fill == LEN_POS) begin
      pad_byte = length[{lsel, 3'b000} +: 8];
    end
  end

  // byte merge
  logic [4:0] shamt;
  always_comb begin
    shamt   = {2'd3 - fill[1:0], 3'b000};
    wr_addr = fill[5:2];
    wr_word = (rd_word & ~(32'hFF << shamt)) | ({24'd0, cur_byte} << shamt);
    wr_en   = (state == S_WRITE);
    rd_addr = (state == S_LOAD) ? load_cnt[3:0] : fill[5:2];
  end

  // round datapath
  logic [31:0] f, k, t, wnew;
  always_comb begin
    if (round < 7'd20) begin
      f = (b & c) | (~b & d); k = K0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d; k = K1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = K2;
    end else begin
      f = b ^ c ^ d; k = K3;
    end
    t = {a[26:0], a[31:27]} + f + e + k + w[0];
    wnew = w[13] ^ w[8] ^ w[2] ^ w[0];
    wnew = {wnew[30:0], wnew[31]};
  end

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      h[0] <= IV0; h[1] <= IV1; h[2] <= IV2; h[3] <= IV3; h[4] <= IV4;
      bit_count <= '0;
      fill      <= '0;
      closing   <= 1'b0;
      pad_started  <= 1'b0;
      length_phase <= 1'b0;
      pad_done     <= 1'b0;
      out_ch.valid <= 1'b0;
      out_idx   <= '0;
      round     <= '0;
      load_cnt  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            closing      <= in_ch.payload.end_of_message;
            pad_started  <= 1'b0;
            length_phase <= 1'b0;
            pad_done     <= 1'b0;
            length  <= bit_count + (in_ch.payload.byte_present ? 64'd8 : 64'd0);
            if (in_ch.payload.byte_present) begin
              bit_count <= bit_count + 64'd8;
              cur_byte  <= in_ch.payload.data_byte;
              state     <= S_WRITE;
            end else if (in_ch.payload.end_of_message) begin
              // empty tail: go straight to padding
              state <= S_PAD;
            end
          end
        end
        S_WRITE: begin
          fill <= fill + 6'd1;
          if (length_phase && fill == 6'd63) begin
            pad_done <= 1'b1;
          end
          if (fill == 6'd63) begin
            load_cnt <= '0;
            state    <= S_LOAD;
          end else if (closing) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_LOAD: begin
          // registered read: word n arrives at count n+1
          if (load_cnt != 5'd0) begin
            w[load_cnt[3:0] - 4'd1] <= rd_word;
          end
          load_cnt <= load_cnt + 5'd1;
          if (load_cnt == 5'd16) begin
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
            round <= '0;
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          a <= t; b <= a; c <= {b[1:0], b[31:2]}; d <= c; e <= d;
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i+1];
          end
          w[15] <= wnew;
          round <= round + 7'd1;
          if (round == 7'd79) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          state <= S_PAD;
        end
        S_PAD: begin
          // back to idle if not closing, else pick the next padding byte or hand over to the output
          if (!closing) begin
            state <= S_IDLE;
          end else if (pad_done) begin
            out_idx      <= '0;
            out_ch.valid <= 1'b1;
            state        <= S_OUT;
          end else begin
            if (!pad_started) begin
              cur_byte    <= PAD_BYTE;
              pad_started <= 1'b1;
            end else begin
              cur_byte <= pad_byte;
              if (fill == LEN_POS) begin
                length_phase <= 1'b1;
              end
            end
            state <= S_WRITE;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            if (out_idx == 3'd4) begin
              out_idx      <= '0;
              out_ch.valid <= 1'b0;
              h[0] <= IV0; h[1] <= IV1; h[2] <= IV2; h[3] <= IV3; h[4] <= IV4;
              bit_count <= '0;
              fill      <= '0;
              closing   <= 1'b0;
              state     <= S_IDLE;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out_ch.payload.digest_word = h[out_idx];
    out_ch.payload.word_index  = out_idx;
    out_ch.payload.last_word   = (out_idx == 3'd4);
  end

endmodule

// ===== dv/tb_sha1_message_digest_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha1_message_digest_unit
// Checks the SHA-1 unit against a behavioral digest predictor. Messages of
// random length and content are streamed byte by byte under several idle and
// stall patterns. Each digest word is compared with the predicted word.
// ----------------------------------------------------------------------------
module tb_sha1_message_digest_unit;
  import sha1_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  sha1_in_if  in_ch ();
  sha1_out_if out_ch ();

  sha1_message_digest_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: chaining words, block being packed, length in bits.
  logic [31:0] hash_words [5];
  logic [31:0] block_words [16];
  logic [63:0] msg_bits;
  logic [5:0]  fill_pos;

  out_beat_t digest_q [$];

  // Pacing knobs, changed between test phases.
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  recv_hold = 1'b0;
  int  fail_count = 0;
  int  idle_cycles = 0;

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // One 80-round compression over block_words, folded into hash_words.
  task automatic run_rounds();
    logic [31:0] sched [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) sched[i] = block_words[i];
    for (int i = 16; i < 80; i++)
      sched[i] = rol(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
    a = hash_words[0]; b = hash_words[1]; c = hash_words[2];
    d = hash_words[3]; e = hash_words[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = rol(a, 5) + f + e + k + sched[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    hash_words[0] += a; hash_words[1] += b; hash_words[2] += c;
    hash_words[3] += d; hash_words[4] += e;
  endtask

  task automatic pack_byte(logic [7:0] by);
    int sh;
    sh = (3 - fill_pos[1:0]) * 8;
    block_words[fill_pos[5:2]][sh +: 8] = by;
    fill_pos = fill_pos + 6'd1;
    if (fill_pos == 6'd0) run_rounds();
  endtask

  task automatic restart_digest();
    hash_words = '{IV0, IV1, IV2, IV3, IV4};
    msg_bits = '0;
    fill_pos = '0;
  endtask

  // Predict the effect of one accepted beat; queue digest words on an end mark.
  task automatic predict_beat(in_beat_t bt);
    logic [63:0] len;
    out_beat_t ob;
    if (bt.byte_present) begin
      msg_bits += 64'd8;
      pack_byte(bt.data_byte);
    end
    if (bt.end_of_message) begin
      len = msg_bits;
      pack_byte(PAD_BYTE);
      while (fill_pos != LEN_POS) pack_byte(8'h00);
      for (int i = 7; i >= 0; i--) pack_byte(len[i*8 +: 8]);
      for (int i = 0; i < 5; i++) begin
        ob.digest_word = hash_words[i];
        ob.word_index  = 3'(i);
        ob.last_word   = (i == 4);
        digest_q.push_back(ob);
      end
      restart_digest();
    end
  endtask

  // Send one beat; holds valid high back to back when no idle is drawn.
  task automatic send_beat(in_beat_t bt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= bt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_beat(bt);
  endtask

  task automatic send_raw(logic [7:0] by, bit pres, bit eom);
    in_beat_t bt;
    bt.data_byte = by; bt.byte_present = pres; bt.end_of_message = eom;
    send_beat(bt);
  endtask

  task automatic send_message(int nbytes, bit tail_empty);
    for (int i = 0; i < nbytes; i++)
      send_raw(8'($urandom), 1'b1, !tail_empty && (i == nbytes - 1));
    if (tail_empty || nbytes == 0) send_raw(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall, or a long hold while recv_hold is set.
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Digest checker and watchdog.
  always @(posedge clk) begin
    out_beat_t exp_b;
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no beat for %0d cycles", $time, idle_cycles);
        $display("tb_sha1_message_digest_unit NOT OK");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t unexpected digest word: actual %h", $time, out_ch.payload);
          fail_count++;
        end else begin
          exp_b = digest_q.pop_front();
          if (out_ch.payload.digest_word !== exp_b.digest_word ||
              out_ch.payload.word_index !== exp_b.word_index ||
              out_ch.payload.last_word !== exp_b.last_word) begin
            $display("%0t digest mismatch: expected %h/%0d/%0b actual %h/%0d/%0b",
                     $time, exp_b.digest_word, exp_b.word_index, exp_b.last_word,
                     out_ch.payload.digest_word, out_ch.payload.word_index,
                     out_ch.payload.last_word);
            fail_count++;
          end
        end
      end
    end
  end

  // Directed: empty message, "abc", no-op beats, one-byte messages.
  task automatic test_directed();
    send_raw(8'h00, 1'b0, 1'b1);
    send_raw(8'hFF, 1'b0, 1'b0);
    send_raw("a", 1'b1, 1'b0);
    send_raw("b", 1'b1, 1'b0);
    send_raw(8'h00, 1'b0, 1'b0);
    send_raw("c", 1'b1, 1'b1);
    send_raw(8'hFF, 1'b1, 1'b1);
    send_raw(8'h00, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_lengths();
    int lens [4] = '{55, 56, 63, 64};
    foreach (lens[i]) send_message(lens[i], i[0]);
    drain();
  endtask

  task automatic test_random(int beats);
    int sent;
    sent = 0;
    while (sent < beats) begin
      int n;
      n = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(12);
      if ($urandom_range(7) == 0) send_raw(8'($urandom), 1'b0, 1'b0);
      send_message(n, $urandom_range(3) == 0);
      sent += n + 1;
    end
    drain();
  endtask

  // Receiver held off while messages keep coming so the input stalls.
  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (600) @(posedge clk);
        recv_hold = 1'b0;
      end
      begin
        repeat (4) send_message($urandom_range(5), 1'b0);
        in_ch.valid <= 1'b0;
      end
    join
    drain();
  endtask

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    restart_digest();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_lengths();
    test_random(60);
    send_idle_pct = 62;
    test_random(50);
    send_idle_pct = 0; recv_stall_pct = 62;
    test_random(50);
    send_idle_pct = 17; recv_stall_pct = 17;
    test_random(50);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_backpressure();

    repeat (200) @(posedge clk);
    if (fail_count == 0 && digest_q.size() == 0) begin
      $display("tb_sha1_message_digest_unit OK");
    end else begin
      $display("%0t %0d failures, %0d digest words missing", $time, fail_count,
               digest_q.size());
      $display("tb_sha1_message_digest_unit NOT OK");
    end
    $finish;
  end

endmodule
